FILE: rtl/ccbw_pkg.sv
// Shared types and constants for the character cell buffer writer.
// Holds cell packing, action and register codes, and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package ccbw_pkg;

  localparam int GLYPH_W  = 16;
  localparam int COLOR_W  = 4;
  localparam int CELL_W   = GLYPH_W + 2 * COLOR_W;
  localparam int ACTION_W = 3;
  localparam int COORD_W  = 8;
  localparam int FW_W     = 8;
  localparam int FH_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [ACTION_W-1:0] ACT_DRAW      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DRAW_FG   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RECOLOR   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [GLYPH_W-1:0] RESET_GLYPH = 16'h0020;
  localparam logic [COLOR_W-1:0] RESET_TEXT  = 4'hF;
  localparam logic [COLOR_W-1:0] RESET_BACK  = 4'h0;

  // Source of the word written into the cell memory.
  typedef enum logic [2:0] {
    WSEL_INIT,
    WSEL_DRAW,
    WSEL_KEEP_BACK,
    WSEL_RECOLOR
  } wsel_t;

  typedef struct packed {
    logic  load;
    logic  idx_clr;
    logic  idx_inc;
    logic  ram_re;
    logic  ram_we;
    logic  addr_idx;
    wsel_t wsel;
    logic  emit;
    logic  emit_clip;
    logic  emit_read;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                in_frame;
    logic                idx_last;
    logic                fill_done;
  } sts_t;

  function automatic logic [CELL_W-1:0] pack_cell(input logic [GLYPH_W-1:0] g,
                                                  input logic [COLOR_W-1:0] t,
                                                  input logic [COLOR_W-1:0] b);
    pack_cell = {b, t, g};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ccbw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ccbw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ccbw_ctrl.sv
// Controller state machine of the character cell buffer writer.
// Depends on ccbw_pkg; drives commands to ccbw_datapath from its status.
`default_nettype none

module ccbw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire ccbw_pkg::sts_t sts,
  output ccbw_pkg::cmd_t     cmd,
  output logic               busy
);

  import ccbw_pkg::*;

  typedef enum logic [6:0] {
    S_INIT    = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_DECODE  = 7'b0000100,
    S_CELL_RD = 7'b0001000,
    S_FILL    = 7'b0010000,
    S_RC_RD   = 7'b0100000,
    S_RC_WR   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      // Clearing pass after reset: every cell gets the reset value.
      S_INIT: begin
        cmd.ram_we   = 1'b1;
        cmd.addr_idx = 1'b1;
        cmd.wsel     = WSEL_INIT;
        cmd.idx_inc  = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_inc = 1'b0;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.action)
          ACT_DRAW, ACT_DRAW_FG, ACT_READ: begin
            if (!sts.in_frame) begin
              cmd.emit      = 1'b1;
              cmd.emit_clip = 1'b1;
              state_nxt     = S_IDLE;
            end else if (sts.action == ACT_DRAW) begin
              cmd.ram_we = 1'b1;
              cmd.wsel   = WSEL_DRAW;
              cmd.emit   = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              cmd.ram_re = 1'b1;
              state_nxt  = S_CELL_RD;
            end
          end
          ACT_CLEAR:   state_nxt = S_FILL;
          ACT_RECOLOR: state_nxt = S_RC_RD;
          default: begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CELL_RD: begin
        cmd.emit = 1'b1;
        if (sts.action == ACT_DRAW_FG) begin
          cmd.ram_we = 1'b1;
          cmd.wsel   = WSEL_KEEP_BACK;
        end else begin
          cmd.emit_read = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_FILL: begin
        if (sts.fill_done) begin
          cmd.idx_clr = 1'b1;
          cmd.emit    = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.ram_we   = 1'b1;
          cmd.addr_idx = 1'b1;
          cmd.wsel     = WSEL_DRAW;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_RC_RD: begin
        if (sts.fill_done) begin
          cmd.idx_clr = 1'b1;
          cmd.emit    = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.ram_re   = 1'b1;
          cmd.addr_idx = 1'b1;
          state_nxt    = S_RC_WR;
        end
      end
      S_RC_WR: begin
        cmd.ram_we   = 1'b1;
        cmd.addr_idx = 1'b1;
        cmd.wsel     = WSEL_RECOLOR;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_RC_RD;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ccbw_datapath.sv
// Datapath of the character cell buffer writer: frame registers, address
// arithmetic, walk counter, cell memory and result registers.
// Depends on ccbw_pkg and ccbw_ram.
`default_nettype none

module ccbw_datapath #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ccbw_pkg::cmd_t                      cmd,
  output ccbw_pkg::sts_t                           sts,
  input  wire logic                                cfg_we,
  input  wire logic [ccbw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ccbw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic [ccbw_pkg::ACTION_W-1:0]       in_action,
  input  wire logic [ccbw_pkg::COORD_W-1:0]        in_col,
  input  wire logic [ccbw_pkg::COORD_W-1:0]        in_row,
  input  wire logic [ccbw_pkg::GLYPH_W-1:0]        in_glyph,
  input  wire logic [ccbw_pkg::COLOR_W-1:0]        in_text_color,
  input  wire logic [ccbw_pkg::COLOR_W-1:0]        in_back_color,
  output logic                                     out_valid,
  output logic                                     out_status,
  output logic [ccbw_pkg::GLYPH_W-1:0]             out_read_glyph,
  output logic [ccbw_pkg::COLOR_W-1:0]             out_read_text_color,
  output logic [ccbw_pkg::COLOR_W-1:0]             out_read_back_color
);

  import ccbw_pkg::*;

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int IDX_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W      = $clog2(MAX_ROWS + 1);
  localparam int PROD_W     = COL_W + ROW_W;
  localparam int EXT_W      = 9;

  // Frame size registers.
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(1);
      frame_height_r <= FH_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size as used: oversized settings saturate at the maximum.
  logic [EXT_W-1:0] width_ext, height_ext, used_w9, used_h9;
  logic [COL_W-1:0] used_w;
  logic [ROW_W-1:0] used_h;

  assign width_ext  = EXT_W'(frame_width_r);
  assign height_ext = EXT_W'(frame_height_r);
  assign used_w9    = (width_ext > EXT_W'(MAX_COLUMNS)) ? EXT_W'(MAX_COLUMNS) : width_ext;
  assign used_h9    = (height_ext > EXT_W'(MAX_ROWS)) ? EXT_W'(MAX_ROWS) : height_ext;
  assign used_w     = COL_W'(used_w9);
  assign used_h     = ROW_W'(used_h9);

  // Address and clipping of the incoming request.
  logic              inside_nxt;
  logic [EXT_W-1:0]  row_diff9;
  logic [ROW_W-1:0]  row_diff;
  logic [PROD_W-1:0] row_base, addr_full, total_full;

  assign inside_nxt = (in_col != '0) && (EXT_W'(in_col) <= used_w9) &&
                      (in_row != '0) && (EXT_W'(in_row) <= used_h9);
  assign row_diff9  = used_h9 - EXT_W'(in_row);
  assign row_diff   = ROW_W'(row_diff9);
  assign row_base   = PROD_W'(used_w) * PROD_W'(row_diff);
  assign addr_full  = row_base + PROD_W'(in_col - COORD_W'(1));
  assign total_full = PROD_W'(used_w) * PROD_W'(used_h);

  logic [ACTION_W-1:0] action_r;
  logic                inside_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [IDX_W-1:0]    total_r;
  logic [GLYPH_W-1:0]  glyph_r;
  logic [COLOR_W-1:0]  text_r, back_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      inside_r <= inside_nxt;
      addr_r   <= ADDR_W'(addr_full);
      total_r  <= IDX_W'(total_full);
      glyph_r  <= in_glyph;
      text_r   <= in_text_color;
      back_r   <= in_back_color;
    end
  end

  // Walk counter shared by the reset clearing pass, clear and recolour.
  logic [IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign sts.action    = action_r;
  assign sts.in_frame  = inside_r;
  assign sts.idx_last  = (idx_r == IDX_W'(CELL_COUNT - 1));
  assign sts.fill_done = (idx_r >= total_r);

  // Cell memory.
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] wdata, rdata;

  assign mem_addr = cmd.addr_idx ? idx_r[ADDR_W-1:0] : addr_r;

  always_comb begin
    case (cmd.wsel)
      WSEL_INIT:      wdata = pack_cell(RESET_GLYPH, RESET_TEXT, RESET_BACK);
      WSEL_DRAW:      wdata = pack_cell(glyph_r, text_r, back_r);
      WSEL_KEEP_BACK: wdata = pack_cell(glyph_r, text_r, rdata[CELL_W-1 -: COLOR_W]);
      WSEL_RECOLOR:   wdata = pack_cell(rdata[GLYPH_W-1:0], text_r, back_r);
      default:        wdata = pack_cell(glyph_r, text_r, back_r);
    endcase
  end

  ccbw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(mem_addr),
    .wdata(wdata),
    .re   (cmd.ram_re),
    .raddr(mem_addr),
    .rdata(rdata)
  );

  // Result registers: the strobe lasts one cycle.
  logic                out_valid_r;
  logic                status_r;
  logic [GLYPH_W-1:0]  rd_glyph_r;
  logic [COLOR_W-1:0]  rd_text_r, rd_back_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r   <= cmd.emit_clip;
      rd_glyph_r <= cmd.emit_read ? rdata[GLYPH_W-1:0] : '0;
      rd_text_r  <= cmd.emit_read ? rdata[GLYPH_W +: COLOR_W] : '0;
      rd_back_r  <= cmd.emit_read ? rdata[CELL_W-1 -: COLOR_W] : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_read_glyph      = rd_glyph_r;
  assign out_read_text_color = rd_text_r;
  assign out_read_back_color = rd_back_r;

endmodule

`default_nettype wire

FILE: rtl/character_cell_buffer_writer_core.sv
// Character cell buffer writer top level: controller plus datapath.
// Depends on ccbw_pkg, ccbw_ctrl, ccbw_datapath and ccbw_ram.
//
// A request is taken when start is high and busy is low; its single result
// appears on the out_ ports for one cycle with out_valid high and cannot be
// held off. After reset the block runs a clearing pass over the whole memory,
// MAX_COLUMNS*MAX_ROWS cells (4096 by default), that writes the reset cell into
// it; busy stays high meanwhile, configuration writes are taken at any time.
// From acceptance to the next possible acceptance, draw, clipped requests and
// unknown actions go through the decode state only; read and the draw that
// keeps the background also go through a cell read state, as the memory read
// port is registered (the latter then writes the cell back); clear writes the
// width*height cells, one per cycle; recolour reads each cell and writes it back.
// The result strobe is high in the same cycle as the next request can be taken.
`default_nettype none

module character_cell_buffer_writer_core #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ccbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ccbw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [ccbw_pkg::ACTION_W-1:0]   in_action,
  input  wire logic [ccbw_pkg::COORD_W-1:0]    in_col,
  input  wire logic [ccbw_pkg::COORD_W-1:0]    in_row,
  input  wire logic [ccbw_pkg::GLYPH_W-1:0]    in_glyph,
  input  wire logic [ccbw_pkg::COLOR_W-1:0]    in_text_color,
  input  wire logic [ccbw_pkg::COLOR_W-1:0]    in_back_color,
  output logic                                 out_valid,
  output logic                                 out_status,
  output logic [ccbw_pkg::GLYPH_W-1:0]         out_read_glyph,
  output logic [ccbw_pkg::COLOR_W-1:0]         out_read_text_color,
  output logic [ccbw_pkg::COLOR_W-1:0]         out_read_back_color
);

  import ccbw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccbw_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  ccbw_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_action),
    .in_col             (in_col),
    .in_row             (in_row),
    .in_glyph           (in_glyph),
    .in_text_color      (in_text_color),
    .in_back_color      (in_back_color),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_glyph     (out_read_glyph),
    .out_read_text_color(out_read_text_color),
    .out_read_back_color(out_read_back_color)
  );

endmodule

`default_nettype wire

FILE: sim/cell_buffer_checker.sv
// Checker for the character cell buffer writer: mirrors the cell memory and
// the frame registers, predicts each reply and compares it with the block.
// Depends on ccbw_pkg; instantiated by the testbench top beside the block.
`default_nettype none

module cell_buffer_checker #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ccbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ccbw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic [ccbw_pkg::ACTION_W-1:0]   in_action,
  input  wire logic [ccbw_pkg::COORD_W-1:0]    in_col,
  input  wire logic [ccbw_pkg::COORD_W-1:0]    in_row,
  input  wire logic [ccbw_pkg::GLYPH_W-1:0]    in_glyph,
  input  wire logic [ccbw_pkg::COLOR_W-1:0]    in_text_color,
  input  wire logic [ccbw_pkg::COLOR_W-1:0]    in_back_color,
  input  wire logic                            out_valid,
  input  wire logic                            out_status,
  input  wire logic [ccbw_pkg::GLYPH_W-1:0]    out_read_glyph,
  input  wire logic [ccbw_pkg::COLOR_W-1:0]    out_read_text_color,
  input  wire logic [ccbw_pkg::COLOR_W-1:0]    out_read_back_color,
  output int                                   mismatches,
  output int                                   outstanding
);

  import ccbw_pkg::*;

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;

  typedef struct packed {
    logic               status;
    logic [GLYPH_W-1:0] glyph;
    logic [COLOR_W-1:0] text;
    logic [COLOR_W-1:0] back;
  } cell_reply_t;

  logic [CELL_W-1:0] cell_mirror [CELLS];
  logic [FW_W-1:0]   width_reg;
  logic [FH_W-1:0]   height_reg;
  cell_reply_t       replies_due [$];

  task automatic report_field(input string field, input logic [GLYPH_W-1:0] want,
                              input logic [GLYPH_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  // Applies one accepted request to the mirror and queues the reply it owes.
  task automatic apply_action();
    cell_reply_t       reply;
    int                cols;
    int                rows;
    int                addr;
    logic [CELL_W-1:0] old_word;
    cols  = (width_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(width_reg);
    rows  = (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
    reply = '0;
    case (in_action)
      ACT_DRAW, ACT_DRAW_FG, ACT_READ: begin
        if (in_col < 1 || in_col > cols || in_row < 1 || in_row > rows) begin
          reply.status = 1'b1;
        end else begin
          // Rows count up from the bottom, memory rows count down from the top.
          addr = (int'(in_col) - 1) + cols * (rows - int'(in_row));
          old_word = cell_mirror[addr];
          if (in_action == ACT_DRAW) begin
            cell_mirror[addr] = {in_back_color, in_text_color, in_glyph};
          end else if (in_action == ACT_DRAW_FG) begin
            cell_mirror[addr] = {old_word[CELL_W-1 -: COLOR_W], in_text_color, in_glyph};
          end else begin
            reply.glyph = old_word[GLYPH_W-1:0];
            reply.text  = old_word[GLYPH_W +: COLOR_W];
            reply.back  = old_word[CELL_W-1 -: COLOR_W];
          end
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < cols * rows; i++)
          cell_mirror[i] = {in_back_color, in_text_color, in_glyph};
      end
      ACT_RECOLOR: begin
        for (int i = 0; i < cols * rows; i++)
          cell_mirror[i] = {in_back_color, in_text_color, cell_mirror[i][GLYPH_W-1:0]};
      end
      default: begin
      end
    endcase
    replies_due = {replies_due, reply};
  endtask

  // Sampled at the falling edge, where every signal has settled since the
  // rising edge that it describes.
  always @(negedge clk) begin
    cell_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++)
        cell_mirror[i] = {RESET_BACK, RESET_TEXT, RESET_GLYPH};
      width_reg  = FW_W'(1);
      height_reg = FH_W'(1);
      replies_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg  = cfg_wdata[FW_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_wdata[FH_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid === 1'b1) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          $display("%0t unexpected reply: expected none, actual status %0d glyph %0h",
                   $time, out_status, out_read_glyph);
        end else begin
          want = replies_due.pop_front();
          report_field("status", GLYPH_W'(want.status), GLYPH_W'(out_status));
          report_field("read_glyph", want.glyph, out_read_glyph);
          report_field("read_text_color", GLYPH_W'(want.text),
                       GLYPH_W'(out_read_text_color));
          report_field("read_back_color", GLYPH_W'(want.back),
                       GLYPH_W'(out_read_back_color));
        end
      end
      if (start && busy === 1'b0)
        apply_action();
    end
    outstanding = replies_due.size();
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Top of the character cell buffer writer testbench: clock, reset, frame
// configuration and request stimulus, plus the final verdict.
// Depends on ccbw_pkg, character_cell_buffer_writer_core and cell_buffer_checker.
`default_nettype none

module testbench;

  import ccbw_pkg::*;

  localparam int MAX_COLUMNS     = 128;
  localparam int MAX_ROWS        = 32;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int FILL_BUDGET     = 8;
  localparam int RUN_LIMIT       = 1_500_000;
  localparam int DRAIN_LIMIT     = 4 * MAX_COLUMNS * MAX_ROWS + 64;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  start         = 1'b0;
  logic [ACTION_W-1:0]   in_action     = '0;
  logic [COORD_W-1:0]    in_col        = '0;
  logic [COORD_W-1:0]    in_row        = '0;
  logic [GLYPH_W-1:0]    in_glyph      = '0;
  logic [COLOR_W-1:0]    in_text_color = '0;
  logic [COLOR_W-1:0]    in_back_color = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_status;
  logic [GLYPH_W-1:0]    out_read_glyph;
  logic [COLOR_W-1:0]    out_read_text_color;
  logic [COLOR_W-1:0]    out_read_back_color;
  int                    mismatches;
  int                    outstanding;

  int frame_cols = 1;
  int frame_rows = 1;
  int fills_done = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  character_cell_buffer_writer_core #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_col             (in_col),
    .in_row             (in_row),
    .in_glyph           (in_glyph),
    .in_text_color      (in_text_color),
    .in_back_color      (in_back_color),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_glyph     (out_read_glyph),
    .out_read_text_color(out_read_text_color),
    .out_read_back_color(out_read_back_color)
  );

  cell_buffer_checker #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) results_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_col             (in_col),
    .in_row             (in_row),
    .in_glyph           (in_glyph),
    .in_text_color      (in_text_color),
    .in_back_color      (in_back_color),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_glyph     (out_read_glyph),
    .out_read_text_color(out_read_text_color),
    .out_read_back_color(out_read_back_color),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  initial begin
    #(RUN_LIMIT * 12);
    $display("%0t run limit reached", $time);
    $display("FAILED: results differ");
    $finish;
  end

  // Presents one request and returns at the rising edge that takes it.
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [COORD_W-1:0] c,
                              input logic [COORD_W-1:0] r, input logic [GLYPH_W-1:0] g,
                              input logic [COLOR_W-1:0] t, input logic [COLOR_W-1:0] b);
    logic taken;
    in_action     <= act;
    in_col        <= c;
    in_row        <= r;
    in_glyph      <= g;
    in_text_color <= t;
    in_back_color <= b;
    start         <= 1'b1;
    taken = 1'b0;
    while (taken !== 1'b1) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  task automatic pause_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Holds off until every reply owed has come back and the block has settled.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_we    <= 1'b0;
    frame_cols = (cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols);
    frame_rows = (rows[FH_W-1:0] > MAX_ROWS) ? MAX_ROWS : int'(rows[FH_W-1:0]);
  endtask

  // Mostly positions inside the frame, some just past each edge, some anywhere.
  function automatic logic [COORD_W-1:0] pick_coord(input int limit);
    int r;
    r = $urandom_range(0, 99);
    if (limit > 0 && r < 88)
      return COORD_W'($urandom_range(1, limit));
    else if (r < 92)
      return 0;
    else if (r < 96)
      return COORD_W'(limit + 1);
    else
      return COORD_W'($urandom_range(0, 255));
  endfunction

  task automatic random_request(input bit allow_fill);
    int                  pick;
    logic [ACTION_W-1:0] act;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      act = ACT_DRAW;
    else if (pick < 50)
      act = ACT_DRAW_FG;
    else if (pick < 80)
      act = ACT_READ;
    else if (pick < 85)
      act = allow_fill ? ACT_CLEAR : ACT_READ;
    else if (pick < 90)
      act = allow_fill ? ACT_RECOLOR : ACT_READ;
    else
      act = ACT_READ + ACTION_W'($urandom_range(1, 3));
    if (act == ACT_CLEAR || act == ACT_RECOLOR)
      fills_done++;
    send_request(act, pick_coord(frame_cols), pick_coord(frame_rows),
                 GLYPH_W'($urandom_range(0, 65535)), COLOR_W'($urandom_range(0, 15)),
                 COLOR_W'($urandom_range(0, 15)));
  endtask

  initial begin
    int plan_cols [PHASES];
    int plan_rows [PHASES];
    bit idling;
    bit big;
    int waited;
    plan_cols = '{1, 0, 9, 128, 255, 200, 5, 0, 0, 3};
    plan_rows = '{1, 5, 0, 32, 63, 7, 40, 0, 0, 2};
    plan_cols[7] = $urandom_range(1, 16);
    plan_rows[7] = $urandom_range(1, 8);
    plan_cols[8] = $urandom_range(1, 40);
    plan_rows[8] = $urandom_range(1, 12);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // The block is still running its clearing pass here, but it takes
    // register writes at any time.
    set_frame(4, 3);

    // Directed requests on a 4 x 3 frame.
    send_request(ACT_READ, 1, 1, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_READ, 4, 3, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_DRAW, 1, 1, 16'hFFFF, 4'hF, 4'hF);
    send_request(ACT_READ, 1, 1, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_DRAW, 4, 3, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_READ, 4, 3, 16'hFFFF, 4'hF, 4'hF);
    send_request(ACT_DRAW_FG, 1, 1, 16'h1234, 4'h5, 4'h9);
    send_request(ACT_READ, 1, 1, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_DRAW, 0, 1, 16'hAAAA, 4'hA, 4'hA);
    send_request(ACT_DRAW_FG, 5, 2, 16'h5555, 4'h5, 4'h5);
    send_request(ACT_READ, 2, 0, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_READ, 3, 4, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_DRAW, 255, 255, 16'hFFFF, 4'hF, 4'hF);
    for (int a = ACT_READ + 1; a < 2 ** ACTION_W; a++)
      send_request(ACTION_W'(a), 1, 1, 16'hBEEF, 4'h6, 4'h7);
    send_request(ACT_READ, 1, 1, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_CLEAR, 0, 0, 16'hABCD, 4'h3, 4'hC);
    send_request(ACT_READ, 2, 2, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_RECOLOR, 9, 9, 16'h5555, 4'h7, 4'h1);
    send_request(ACT_READ, 3, 1, 16'h0000, 4'h0, 4'h0);
    send_request(ACT_READ, 4, 3, 16'h0000, 4'h0, 4'h0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_frame(CFG_DATA_W'(plan_cols[p]), CFG_DATA_W'(plan_rows[p]));
      fills_done = 0;
      idling     = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // The last phase runs back to back.
        if (p != PHASES - 1) begin
          if ($urandom_range(0, 19) == 0)
            idling = !idling;
          if (idling && $urandom_range(0, 3) == 0)
            pause_cycles($urandom_range(1, 4));
          if ($urandom_range(0, 79) == 0)
            drain();
        end
        // Whole-frame passes on large frames are slow, so they are rationed.
        big = frame_cols * frame_rows > 256;
        random_request(!big || fills_done < FILL_BUDGET);
      end
    end
    start <= 1'b0;

    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (outstanding != 0) begin
      $display("%0t timed out with %0d replies outstanding", $time, outstanding);
      $display("FAILED: results differ");
    end else begin
      repeat (8) @(posedge clk);
      if (mismatches == 0 && outstanding == 0)
        $display("PASSED: all results match");
      else
        $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
